// ----- rtl/m64alu_pkg.sv -----
// Shared types and constants for the 64-bit integer ALU with register file.
package m64alu_pkg;

  localparam int DataW  = 64;
  localparam int WordW  = 32;
  localparam int IdxW   = 5;
  localparam int TypeW  = 4;

  // Request codes as they arrive on the request channel.
  typedef enum logic [TypeW-1:0] {
    REQ_LOAD = 4'd0,
    REQ_READ = 4'd1,
    OP_ADD   = 4'd2,
    OP_ADDU  = 4'd3,
    OP_DADD  = 4'd4,
    OP_DADDU = 4'd5,
    OP_SUB   = 4'd6,
    OP_SUBU  = 4'd7,
    OP_DSUB  = 4'd8,
    OP_DSUBU = 4'd9,
    OP_AND   = 4'd10,
    OP_OR    = 4'd11,
    OP_XOR   = 4'd12,
    OP_NOR   = 4'd13,
    OP_SLT   = 4'd14,
    OP_SLTU  = 4'd15
  } req_code_t;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_READ,
    KIND_ALU
  } kind_t;

  typedef enum logic [2:0] {
    FN_ADD,
    FN_SUB,
    FN_AND,
    FN_OR,
    FN_XOR,
    FN_NOR,
    FN_SLT,
    FN_SLTU
  } alu_fn_t;

  // One decoded request as it waits in the queue.
  typedef struct packed {
    kind_t             kind;
    alu_fn_t           fn;
    logic              word;
    logic [IdxW-1:0]   src_a;
    logic [IdxW-1:0]   src_b;
    logic [IdxW-1:0]   dest;
    logic [DataW-1:0]  load_value;
  } entry_t;

endpackage

// ----- rtl/m64alu_if.sv -----
// Request and response channel interfaces.
interface m64alu_req_if import m64alu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TypeW-1:0]  req_type;
  logic [IdxW-1:0]   source_a_index;
  logic [IdxW-1:0]   source_b_index;
  logic [IdxW-1:0]   dest_index;
  logic [DataW-1:0]  load_value;

  modport source (output valid, req_type, source_a_index, source_b_index, dest_index,
                  load_value, input ready);
  modport sink (input valid, req_type, source_a_index, source_b_index, dest_index,
                load_value, output ready);
endinterface

interface m64alu_rsp_if import m64alu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DataW-1:0]  result_value;
  logic [IdxW-1:0]   written_index;

  modport source (output valid, result_value, written_index, input ready);
  modport sink (input valid, result_value, written_index, output ready);
endinterface

// ----- rtl/m64alu_front.sv -----
// Front end: accept request words and decode them into queue entries.
module m64alu_front import m64alu_pkg::*; (
  m64alu_req_if.sink  req,
  input  logic        q_full,
  output logic        push,
  output entry_t      push_entry
);

  req_code_t code;

  assign code     = req_code_t'(req.req_type);
  assign req.ready = !q_full;
  assign push     = req.valid && !q_full;

  always_comb begin
    push_entry            = '0;
    push_entry.src_a      = req.source_a_index;
    push_entry.src_b      = req.source_b_index;
    push_entry.dest       = req.dest_index;
    push_entry.load_value = req.load_value;
    push_entry.word       = code inside {OP_ADD, OP_ADDU, OP_SUB, OP_SUBU};
    push_entry.kind       = KIND_ALU;
    push_entry.fn         = FN_ADD;
    case (code)
      REQ_LOAD:                            push_entry.kind = KIND_LOAD;
      REQ_READ:                            push_entry.kind = KIND_READ;
      OP_ADD, OP_ADDU, OP_DADD, OP_DADDU:  push_entry.fn = FN_ADD;
      OP_SUB, OP_SUBU, OP_DSUB, OP_DSUBU:  push_entry.fn = FN_SUB;
      OP_AND:                              push_entry.fn = FN_AND;
      OP_OR:                               push_entry.fn = FN_OR;
      OP_XOR:                              push_entry.fn = FN_XOR;
      OP_NOR:                              push_entry.fn = FN_NOR;
      OP_SLT:                              push_entry.fn = FN_SLT;
      OP_SLTU:                             push_entry.fn = FN_SLTU;
      default:                             push_entry.fn = FN_ADD;
    endcase
  end

endmodule

// ----- rtl/m64alu_queue.sv -----
// Small FIFO of decoded entries between front and back end.
module m64alu_queue import m64alu_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  entry_t                       push_entry,
  input  logic                         pop,
  output entry_t                       head,
  output logic                         empty,
  output logic                         full,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  entry_t           slots [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CntW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/m64alu_back.sv -----
// Back end: register file read, ALU, write back and response register.
module m64alu_back import m64alu_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  entry_t        head,
  input  logic          q_empty,
  output logic          pop,
  m64alu_rsp_if.source  rsp
);

  localparam int RegCount = 1 << IdxW;

  logic [DataW-1:0]    regs [RegCount];
  logic [RegCount-1:0] reg_valid;

  logic [DataW-1:0]    rd_a;
  logic [DataW-1:0]    rd_b;

  logic                x_valid;
  kind_t               x_kind;
  alu_fn_t             x_fn;
  logic                x_word;
  logic [IdxW-1:0]     x_src_a;
  logic [IdxW-1:0]     x_dest;
  logic [DataW-1:0]    x_load_value;
  logic                x_va;
  logic                x_vb;
  logic                x_fwd_a;
  logic                x_fwd_b;
  logic [DataW-1:0]    x_fwd_value;

  logic                out_valid;
  logic [DataW-1:0]    out_value;
  logic [IdxW-1:0]     out_index;

  logic                x_fire;
  logic                advance;
  logic                wr_en;
  logic [DataW-1:0]    op_a;
  logic [DataW-1:0]    op_b;
  logic                sub;
  logic                flip;
  logic [DataW-1:0]    a_in;
  logic [DataW-1:0]    b_in;
  logic [DataW:0]      sum;
  logic                lt;
  logic [DataW-1:0]    alu_value;
  logic [DataW-1:0]    result;

  assign x_fire  = x_valid && (!out_valid || rsp.ready);
  assign advance = !q_empty && (!x_valid || x_fire);
  assign pop     = advance;
  assign wr_en   = x_fire && (x_kind != KIND_READ) && (x_dest != '0);

  // Register file: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) regs[x_dest] <= result;
    if (advance) begin
      rd_a <= regs[head.src_a];
      rd_b <= regs[head.src_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_valid <= '0;
      x_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (wr_en) reg_valid[x_dest] <= 1'b1;
      if (advance)     x_valid <= 1'b1;
      else if (x_fire) x_valid <= 1'b0;
      if (x_fire)         out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  // Execute stage payload; forward the write that retires this cycle.
  always_ff @(posedge clk) begin
    if (advance) begin
      x_kind       <= head.kind;
      x_fn         <= head.fn;
      x_word       <= head.word;
      x_src_a      <= head.src_a;
      x_dest       <= head.dest;
      x_load_value <= head.load_value;
      x_va         <= reg_valid[head.src_a];
      x_vb         <= reg_valid[head.src_b];
      x_fwd_a      <= wr_en && (x_dest == head.src_a);
      x_fwd_b      <= wr_en && (x_dest == head.src_b);
      x_fwd_value  <= result;
    end
    if (x_fire) begin
      out_value <= result;
      out_index <= (x_kind == KIND_READ) ? x_src_a : x_dest;
    end
  end

  assign op_a = x_fwd_a ? x_fwd_value : (x_va ? rd_a : '0);
  assign op_b = x_fwd_b ? x_fwd_value : (x_vb ? rd_b : '0);

  // One adder serves add, subtract and both compares.
  assign sub  = x_fn inside {FN_SUB, FN_SLT, FN_SLTU};
  assign flip = (x_fn == FN_SLT);
  assign a_in = {op_a[DataW-1] ^ flip, op_a[DataW-2:0]};
  assign b_in = {op_b[DataW-1] ^ flip, op_b[DataW-2:0]};
  assign sum  = {1'b0, a_in} + {1'b0, (sub ? ~b_in : b_in)} + {{DataW{1'b0}}, sub};
  assign lt   = !sum[DataW];

  always_comb begin
    case (x_fn)
      FN_ADD, FN_SUB: alu_value = x_word ? {{(DataW-WordW){sum[WordW-1]}}, sum[WordW-1:0]}
                                         : sum[DataW-1:0];
      FN_AND:         alu_value = op_a & op_b;
      FN_OR:          alu_value = op_a | op_b;
      FN_XOR:         alu_value = op_a ^ op_b;
      FN_NOR:         alu_value = ~(op_a | op_b);
      FN_SLT, FN_SLTU: alu_value = {{(DataW-1){1'b0}}, lt};
      default:        alu_value = '0;
    endcase
  end

  always_comb begin
    case (x_kind)
      KIND_LOAD: result = x_load_value;
      KIND_READ: result = op_a;
      default:   result = alu_value;
    endcase
  end

  assign rsp.valid         = out_valid;
  assign rsp.result_value  = out_value;
  assign rsp.written_index = out_index;

endmodule

// ----- rtl/mips64_integer_alu_regfile.sv -----
// Top level of the 64-bit integer ALU with 32-entry register file.
//
//   channel | dir | word carries
//   --------+-----+-----------------------------------------------------------
//   req     | in  | req_type, source_a_index, source_b_index, dest_index, load_value
//   rsp     | out | result_value, written_index
//
// Cycles: one word per cycle sustained while rsp.ready stays high. A word is
// written into the queue, has its operands read from the register file as it
// enters the execute stage (64-bit ALU), then sits in the response register.
// Reset: synchronous; empties the queue and pipeline and marks every register
// as zero through a valid bit per entry, so no clearing pass is needed.
// Stalls: a held response blocks execute; the queue keeps taking words until
// full, then req.ready drops.
module mips64_integer_alu_regfile import m64alu_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  m64alu_req_if.sink    req,
  m64alu_rsp_if.source  rsp
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic             push;
  entry_t           push_entry;
  logic             pop;
  entry_t           head;
  logic             q_empty;
  logic             q_full;
  logic [CntW-1:0]  q_count;

  // Decode incoming words.
  m64alu_front u_front (
    .req        (req),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decouple decode from execute.
  m64alu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full),
    .count      (q_count)
  );

  // Read operands, execute, write back and hold the response.
  m64alu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .rsp     (rsp)
  );

  // Occupancy never exceeds the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CntW'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  // The back end never pops an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("pop from empty queue");

  // A push with no pop grows the count by one.
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (q_count == $past(q_count) + 1'b1))
    else $error("queue count did not advance on push");

endmodule
